// ----- rtl/lfrs_pkg.sv -----
// shared types and constants of the lowest-free-room scheduler
package lfrs_pkg;

  localparam int MAX_ROOMS_DEF = 16;  // built room count
  localparam int IN_TIME_W     = 40;  // meeting times on the input side
  localparam int TIME_W        = 48;  // scheduled times and busy-until times
  localparam int CNT_W         = 16;  // per-room use count
  localparam int ROOM_W        = 4;   // room index fields on the output side
  localparam int RC_W          = 5;   // room_count register
  localparam logic [RC_W-1:0] RC_RESET = RC_W'(16);

  localparam int IN_DATA_W  = 2 * IN_TIME_W;
  localparam int OUT_DATA_W = 2 * ROOM_W + 2 * TIME_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_UPDATE,
    ST_TALLY,
    ST_TDRAIN,
    ST_EMIT
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic load;         // capture the input beat, restart the scan
    logic scan_rd;      // issue a room read and step the room index
    logic tally;        // current pass looks at use counts
    logic update;       // write the chosen room, latch the result
    logic tally_start;  // restart the room index for the count pass
    logic clear_rooms;  // drop every room back to its empty state
    logic emit;         // move the result into the output register
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic at_last;      // room index sits on the last room in use
    logic out_free;     // output register can take a result
    logic last_item;    // captured beat closes the batch
  } status_t;

endpackage

// ----- rtl/lowest_free_room_scheduler_top.sv -----
// top level of the lowest-free-room meeting scheduler
//
//  channel   dir  handshake                  payload
//  s_axis    in   tvalid/tready              tdata: meeting_start, meeting_end; tlast: last
//  m_axis    out  tvalid/tready              tdata: room, start, end, busiest; tuser: delayed;
//                                            tlast: batch_done
//  cfg       in   cfg_we_i (no wait)         cfg_wdata_i: room_count
//
// a meeting passes these steps from one input beat to the next:
// an accept, a read of each room in use, a drain, an update and a hand-off.
// the beat that closes a batch adds a use-count pass over the rooms in use.
// the room scan runs through the single read port of the room tables.
// reset clears all rooms at once through per-room valid bits; no clearing pass.
// a stalled output holds the finished result in the output register; the next
// beat is taken meanwhile and waits only at hand-off.
module lowest_free_room_scheduler_top #(
  parameter int MAX_ROOMS = lfrs_pkg::MAX_ROOMS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // configuration
  input  logic                               cfg_we_i,
  input  logic [lfrs_pkg::RC_W-1:0]          cfg_wdata_i,   // room_count
  // meetings in
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [lfrs_pkg::IN_DATA_W-1:0]     s_axis_tdata,  // meeting_start, meeting_end
  input  logic                               s_axis_tlast,  // last_meeting
  // schedule out
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // assigned_room, actual_start, actual_end, busiest_room
  output logic [lfrs_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
  output logic                               m_axis_tuser,  // was_delayed
  output logic                               m_axis_tlast   // batch_done
);
  import lfrs_pkg::*;

  localparam int IdxW = (MAX_ROOMS > 1) ? $clog2(MAX_ROOMS) : 1;

  logic [RC_W-1:0] room_count_q;
  logic [IdxW-1:0] last_idx;

  cmd_t    cmd;
  status_t sts;

  logic [ROOM_W-1:0] assigned_room;
  logic [TIME_W-1:0] actual_start;
  logic [TIME_W-1:0] actual_end;
  logic [ROOM_W-1:0] busiest_room;

  // room_count register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      room_count_q <= RC_RESET;
    end else if (cfg_we_i) begin
      room_count_q <= cfg_wdata_i;
    end
  end

  // last room index scanned: zero rooms act as one, too many clamp to the built count
  always_comb begin
    priority if (room_count_q == '0) begin
      last_idx = '0;
    end else if (int'(room_count_q) > MAX_ROOMS) begin
      last_idx = IdxW'(MAX_ROOMS - 1);
    end else begin
      last_idx = IdxW'(room_count_q - 1'b1);
    end
  end

  lfrs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  lfrs_dp #(.MAX_ROOMS(MAX_ROOMS)) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .last_idx_i      (last_idx),
    .meeting_start_i (s_axis_tdata[IN_TIME_W-1:0]),
    .meeting_end_i   (s_axis_tdata[IN_DATA_W-1:IN_TIME_W]),
    .last_meeting_i  (s_axis_tlast),
    .out_valid_o     (m_axis_tvalid),
    .out_ready_i     (m_axis_tready),
    .assigned_room_o (assigned_room),
    .actual_start_o  (actual_start),
    .actual_end_o    (actual_end),
    .was_delayed_o   (m_axis_tuser),
    .busiest_room_o  (busiest_room),
    .batch_done_o    (m_axis_tlast)
  );

  assign m_axis_tdata = {busiest_room, actual_end, actual_start, assigned_room};

endmodule

// ----- rtl/lfrs_ram.sv -----
// generic single-port-write ram with registered read
module lfrs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                clk_i,
  input  logic                                we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                    wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                    rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/lfrs_ctrl.sv -----
// sequencing state machine of the scheduler
module lfrs_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  lfrs_pkg::status_t sts_i,
  output lfrs_pkg::cmd_t   cmd_o
);
  import lfrs_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd_o.scan_rd = 1'b1;
        if (sts_i.at_last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_d = ST_UPDATE;
      end
      ST_UPDATE: begin
        cmd_o.update = 1'b1;
        if (sts_i.last_item) begin
          cmd_o.tally_start = 1'b1;
          state_d           = ST_TALLY;
        end else begin
          state_d = ST_EMIT;
        end
      end
      ST_TALLY: begin
        cmd_o.tally   = 1'b1;
        cmd_o.scan_rd = 1'b1;
        if (sts_i.at_last) begin
          state_d = ST_TDRAIN;
        end
      end
      ST_TDRAIN: begin
        cmd_o.tally       = 1'b1;
        cmd_o.clear_rooms = 1'b1;
        state_d           = ST_EMIT;
      end
      ST_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

// ----- rtl/lfrs_dp.sv -----
// room tables, scan trackers, update arithmetic and output register
module lfrs_dp #(
  parameter int MAX_ROOMS = lfrs_pkg::MAX_ROOMS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  lfrs_pkg::cmd_t                      cmd_i,
  output lfrs_pkg::status_t                   sts_o,
  input  logic [((MAX_ROOMS > 1) ? $clog2(MAX_ROOMS) : 1)-1:0] last_idx_i,
  input  logic [lfrs_pkg::IN_TIME_W-1:0]      meeting_start_i,
  input  logic [lfrs_pkg::IN_TIME_W-1:0]      meeting_end_i,
  input  logic                                last_meeting_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [lfrs_pkg::ROOM_W-1:0]         assigned_room_o,
  output logic [lfrs_pkg::TIME_W-1:0]         actual_start_o,
  output logic [lfrs_pkg::TIME_W-1:0]         actual_end_o,
  output logic                                was_delayed_o,
  output logic [lfrs_pkg::ROOM_W-1:0]         busiest_room_o,
  output logic                                batch_done_o
);
  import lfrs_pkg::*;

  localparam int IdxW = (MAX_ROOMS > 1) ? $clog2(MAX_ROOMS) : 1;

  // captured beat
  logic [TIME_W-1:0]    start_q;
  logic [IN_TIME_W-1:0] dur_q;
  logic                 last_q;

  // scan index and read pipeline
  logic [IdxW-1:0] idx_q;
  logic            chk_vld_q;
  logic [IdxW-1:0] chk_idx_q;

  // per-room valid bits, cleared by reset and at batch end
  logic [MAX_ROOMS-1:0] valid_q;

  // trackers
  logic              found_q;
  logic [IdxW-1:0]   free_idx_q;
  logic [CNT_W-1:0]  free_cnt_q;
  logic [TIME_W-1:0] min_q;
  logic [IdxW-1:0]   min_idx_q;
  logic [CNT_W-1:0]  min_cnt_q;
  logic [CNT_W-1:0]  most_q;
  logic [IdxW-1:0]   busiest_q;

  // result waiting for the output register
  logic [IdxW-1:0]   res_room_q;
  logic [TIME_W-1:0] res_start_q;
  logic [TIME_W-1:0] res_end_q;
  logic              res_delayed_q;

  // output register
  logic              out_valid_q;
  logic [ROOM_W-1:0] out_room_q;
  logic [TIME_W-1:0] out_start_q;
  logic [TIME_W-1:0] out_end_q;
  logic              out_delayed_q;
  logic [ROOM_W-1:0] out_busiest_q;
  logic              out_done_q;

  logic [TIME_W-1:0] busy_rd;
  logic [CNT_W-1:0]  cnt_rd;
  logic [TIME_W-1:0] busy_eff;
  logic [CNT_W-1:0]  cnt_eff;
  logic              entry_ok;

  logic [IdxW-1:0]   pick;
  logic [TIME_W-1:0] sel_start;
  logic [CNT_W-1:0]  sel_cnt;
  logic [TIME_W:0]   end_sum;
  logic [TIME_W-1:0] new_end;
  logic [CNT_W-1:0]  new_cnt;
  logic              out_free;

  lfrs_ram #(.WIDTH(TIME_W), .DEPTH(MAX_ROOMS)) u_busy_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.update),
    .waddr_i (pick),
    .wdata_i (new_end),
    .raddr_i (idx_q),
    .rdata_o (busy_rd)
  );

  lfrs_ram #(.WIDTH(CNT_W), .DEPTH(MAX_ROOMS)) u_cnt_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.update),
    .waddr_i (pick),
    .wdata_i (new_cnt),
    .raddr_i (idx_q),
    .rdata_o (cnt_rd)
  );

  // a room never written since the last clear reads as empty
  assign entry_ok = valid_q[chk_idx_q];
  assign busy_eff = entry_ok ? busy_rd : '0;
  assign cnt_eff  = entry_ok ? cnt_rd : '0;

  assign pick      = found_q ? free_idx_q : min_idx_q;
  assign sel_start = found_q ? start_q : min_q;
  assign sel_cnt   = found_q ? free_cnt_q : min_cnt_q;
  assign end_sum   = {1'b0, sel_start} + (TIME_W + 1)'(dur_q);
  assign new_end   = end_sum[TIME_W] ? '1 : end_sum[TIME_W-1:0];
  assign new_cnt   = (sel_cnt == '1) ? sel_cnt : sel_cnt + 1'b1;

  assign out_free = !out_valid_q || out_ready_i;

  assign sts_o.at_last   = (idx_q == last_idx_i);
  assign sts_o.out_free  = out_free;
  assign sts_o.last_item = last_q;

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      chk_vld_q   <= 1'b0;
      valid_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.load || cmd_i.tally_start) begin
        idx_q <= '0;
      end else if (cmd_i.scan_rd && !sts_o.at_last) begin
        idx_q <= idx_q + 1'b1;
      end
      chk_vld_q <= cmd_i.scan_rd;
      if (cmd_i.clear_rooms) begin
        valid_q <= '0;
      end else if (cmd_i.update) begin
        valid_q[pick] <= 1'b1;
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    chk_idx_q <= idx_q;
    if (cmd_i.load) begin
      start_q    <= TIME_W'(meeting_start_i);
      dur_q      <= (meeting_end_i > meeting_start_i) ?
                    meeting_end_i - meeting_start_i : '0;
      last_q     <= last_meeting_i;
      found_q    <= 1'b0;
      free_idx_q <= '0;
      free_cnt_q <= '0;
      min_q      <= '1;
      min_idx_q  <= '0;
      min_cnt_q  <= '0;
      most_q     <= '0;
      busiest_q  <= '0;
    end else if (chk_vld_q && !cmd_i.tally) begin
      if (!found_q && (busy_eff <= start_q)) begin
        found_q    <= 1'b1;
        free_idx_q <= chk_idx_q;
        free_cnt_q <= cnt_eff;
      end
      if ((chk_idx_q == '0) || (busy_eff < min_q)) begin
        min_q     <= busy_eff;
        min_idx_q <= chk_idx_q;
        min_cnt_q <= cnt_eff;
      end
    end else if (chk_vld_q && cmd_i.tally) begin
      if (cnt_eff > most_q) begin
        most_q    <= cnt_eff;
        busiest_q <= chk_idx_q;
      end
    end
    if (cmd_i.update) begin
      res_room_q    <= pick;
      res_start_q   <= sel_start;
      res_end_q     <= new_end;
      res_delayed_q <= !found_q;
    end
    if (cmd_i.emit) begin
      out_room_q    <= ROOM_W'(res_room_q);
      out_start_q   <= res_start_q;
      out_end_q     <= res_end_q;
      out_delayed_q <= res_delayed_q;
      out_busiest_q <= last_q ? ROOM_W'(busiest_q) : '0;
      out_done_q    <= last_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign assigned_room_o = out_room_q;
  assign actual_start_o  = out_start_q;
  assign actual_end_o    = out_end_q;
  assign was_delayed_o   = out_delayed_q;
  assign busiest_room_o  = out_busiest_q;
  assign batch_done_o    = out_done_q;

endmodule

// ----- test/tb_top.sv -----
// self-checking testbench for the lowest-free-room meeting scheduler
`timescale 1ns / 1ps

module tb_top;
  import lfrs_pkg::*;

  localparam int STALL_LIMIT = 4000;
  localparam int DRAIN_WAIT  = 60;
  localparam int RANDOM_MEETINGS = 1000;
  localparam int SAT_MEETINGS    = 280;
  localparam int FAST_MEETINGS   = 100;
  localparam logic [TIME_W-1:0]    TIME_TOP = '1;
  localparam logic [CNT_W-1:0]     CNT_TOP  = '1;
  localparam logic [IN_TIME_W-1:0] IN_TOP   = '1;

  typedef struct packed {
    logic [ROOM_W-1:0] room;
    logic [TIME_W-1:0] t_start;
    logic [TIME_W-1:0] t_end;
    logic              delayed;
    logic [ROOM_W-1:0] busiest;
    logic              done;
  } sched_t;

  typedef struct packed {
    logic                 is_cfg;
    logic [RC_W-1:0]      rooms;
    logic [IN_TIME_W-1:0] t_s;
    logic [IN_TIME_W-1:0] t_e;
    logic                 last_m;
    logic                 typed;
    sched_t               want;
  } step_row_t;

  localparam sched_t NO_WANT = '0;
  localparam int N_ROWS = 18;

  // opening sequence: extremes, zero durations, out-of-order starts, odd room counts
  localparam step_row_t OPENING [N_ROWS] = '{
    '{1'b0, 5'd0, 40'd0, 40'd10, 1'b0, 1'b1, '{4'd0, 48'd0, 48'd10, 1'b0, 4'd0, 1'b0}},
    '{1'b0, 5'd0, 40'd0, 40'd5, 1'b0, 1'b1, '{4'd1, 48'd0, 48'd5, 1'b0, 4'd0, 1'b0}},
    '{1'b0, 5'd0, 40'd5, 40'd5, 1'b0, 1'b1, '{4'd1, 48'd5, 48'd5, 1'b0, 4'd0, 1'b0}},
    '{1'b0, 5'd0, 40'd3, 40'd1, 1'b0, 1'b0, NO_WANT},
    '{1'b0, 5'd0, IN_TOP, IN_TOP, 1'b1, 1'b1,
      '{4'd0, {8'd0, IN_TOP}, {8'd0, IN_TOP}, 1'b0, 4'd0, 1'b1}},
    '{1'b1, 5'd0, 40'd0, 40'd0, 1'b0, 1'b0, NO_WANT},
    '{1'b0, 5'd0, 40'd0, IN_TOP, 1'b0, 1'b1,
      '{4'd0, 48'd0, {8'd0, IN_TOP}, 1'b0, 4'd0, 1'b0}},
    '{1'b0, 5'd0, 40'd1, 40'd2, 1'b0, 1'b0, NO_WANT},
    '{1'b1, 5'd31, 40'd0, 40'd0, 1'b0, 1'b0, NO_WANT},
    '{1'b0, 5'd0, 40'd0, 40'd1, 1'b0, 1'b0, NO_WANT},
    '{1'b1, 5'd2, 40'd0, 40'd0, 1'b0, 1'b0, NO_WANT},
    '{1'b0, 5'd0, 40'd2, 40'd4, 1'b0, 1'b0, NO_WANT},
    '{1'b0, 5'd0, 40'd3, 40'd9, 1'b0, 1'b0, NO_WANT},
    '{1'b1, 5'd17, 40'd0, 40'd0, 1'b0, 1'b0, NO_WANT},
    '{1'b0, 5'd0, 40'd0, 40'd0, 1'b1, 1'b0, NO_WANT},
    '{1'b1, 5'd16, 40'd0, 40'd0, 1'b0, 1'b0, NO_WANT},
    '{1'b0, 5'd0, 40'd0, 40'd0, 1'b1, 1'b1, '{4'd0, 48'd0, 48'd0, 1'b0, 4'd0, 1'b1}},
    '{1'b0, 5'd0, IN_TOP, 40'd0, 1'b0, 1'b0, NO_WANT}
  };

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [RC_W-1:0]       cfg_wdata_i = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic                  s_axis_tlast = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  m_axis_tuser;
  logic                  m_axis_tlast;

  // predictor state
  logic [TIME_W-1:0] busy_until [MAX_ROOMS_DEF];
  logic [CNT_W-1:0]  use_cnt [MAX_ROOMS_DEF];
  logic [RC_W-1:0]   room_reg;

  sched_t sched_q [$];

  int  n_fail = 0;
  int  n_meetings = 0;
  int  n_delayed = 0;
  int  n_closes = 0;
  int  n_cfg = 0;
  int  idle_cycles = 0;
  int  burst_left = 0;
  bit  fast = 1'b0;

  logic [15:0] stall_pat = 16'hffff;
  int          pat_age = 0;

  lowest_free_room_scheduler_top i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [IN_TIME_W-1:0] rand_time();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[IN_TIME_W-1:0];
  endfunction

  function void clear_rooms();
    for (int i = 0; i < MAX_ROOMS_DEF; i++) begin
      busy_until[i] = '0;
      use_cnt[i] = '0;
    end
  endfunction

  // schedule one meeting against the predictor state
  function void schedule_meeting(input logic [IN_TIME_W-1:0] t_s, input logic [IN_TIME_W-1:0] t_e,
                                 input logic last_m, output sched_t res);
    int n;
    int pick;
    bit found;
    logic [TIME_W-1:0] dur;
    logic [TIME_W-1:0] st;
    logic [TIME_W-1:0] en;
    logic [CNT_W-1:0]  most;
    n = (room_reg == 0) ? 1 : ((room_reg > MAX_ROOMS_DEF) ? MAX_ROOMS_DEF : int'(room_reg));
    dur = (t_e > t_s) ? TIME_W'(t_e - t_s) : '0;
    pick = 0;
    found = 1'b0;
    for (int i = 0; i < n; i++) begin
      if (!found && busy_until[i] <= TIME_W'(t_s)) begin
        pick = i;
        found = 1'b1;
      end
    end
    if (found) begin
      st = TIME_W'(t_s);
    end else begin
      // nothing free: earliest busy-until room, lowest index on ties
      st = busy_until[0];
      for (int i = 1; i < n; i++) begin
        if (busy_until[i] < st) begin
          st = busy_until[i];
          pick = i;
        end
      end
    end
    en = (dur > TIME_TOP - st) ? TIME_TOP : st + dur;
    busy_until[pick] = en;
    if (use_cnt[pick] != CNT_TOP) use_cnt[pick] = use_cnt[pick] + 1'b1;
    res.room = ROOM_W'(pick);
    res.t_start = st;
    res.t_end = en;
    res.delayed = !found;
    res.busiest = '0;
    res.done = last_m;
    if (last_m) begin
      most = '0;
      for (int i = 0; i < n; i++) begin
        if (use_cnt[i] > most) begin
          most = use_cnt[i];
          res.busiest = ROOM_W'(i);
        end
      end
      clear_rooms();
      n_closes++;
    end
    if (!found) n_delayed++;
  endfunction

  task automatic drop_valid();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
  endtask

  // offer one meeting, in bursts with gaps unless running flat out
  task automatic send_meeting(input logic [IN_TIME_W-1:0] t_s, input logic [IN_TIME_W-1:0] t_e,
                              input logic last_m, input bit typed, input sched_t want);
    int gap;
    sched_t res;
    if (!fast) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 20);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        if (gap > 0) begin
          drop_valid();
          repeat (gap - 1) @(negedge clk_i);
        end
      end
      burst_left--;
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {t_e, t_s};
    s_axis_tlast  <= last_m;
    do @(posedge clk_i); while (!s_axis_tready);
    schedule_meeting(t_s, t_e, last_m, res);
    sched_q.push_back(typed ? want : res);
    n_meetings++;
  endtask

  // hold the sender until every expected result has come out
  task automatic wait_drained();
    drop_valid();
    while (sched_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_rooms(input logic [RC_W-1:0] v);
    wait_drained();
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    room_reg = v;
    n_cfg++;
  endtask

  function automatic logic [RC_W-1:0] pick_rooms();
    case ($urandom_range(0, 9))
      0:       return RC_W'(1);
      1:       return RC_W'(16);
      2:       return RC_W'(0);
      3:       return RC_W'($urandom_range(17, 31));
      default: return RC_W'($urandom_range(1, 16));
    endcase
  endfunction

  // receiver stalls from a rotating pattern that is reloaded now and then
  always @(negedge clk_i) begin
    m_axis_tready <= fast ? 1'b1 : stall_pat[0];
    if (pat_age == 150) begin
      pat_age <= 0;
      case ($urandom_range(0, 3))
        0:       stall_pat <= 16'hffff;
        1:       stall_pat <= 16'h0101;
        default: stall_pat <= 16'($urandom) | 16'h0001;
      endcase
    end else begin
      pat_age <= pat_age + 1;
      stall_pat <= {stall_pat[0], stall_pat[15:1]};
    end
  end

  // result checker
  always @(posedge clk_i) begin
    sched_t want;
    sched_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.room    = m_axis_tdata[ROOM_W-1:0];
      got.t_start = m_axis_tdata[ROOM_W +: TIME_W];
      got.t_end   = m_axis_tdata[ROOM_W+TIME_W +: TIME_W];
      got.busiest = m_axis_tdata[ROOM_W+2*TIME_W +: ROOM_W];
      got.delayed = m_axis_tuser;
      got.done    = m_axis_tlast;
      if (sched_q.size() == 0) begin
        $error("result beat with nothing expected");
        n_fail++;
      end else begin
        want = sched_q.pop_front();
        if (got.room !== want.room) begin
          $error("assigned_room: expected %0d, got %0d", want.room, got.room);
          n_fail++;
        end
        if (got.t_start !== want.t_start) begin
          $error("actual_start: expected %0h, got %0h", want.t_start, got.t_start);
          n_fail++;
        end
        if (got.t_end !== want.t_end) begin
          $error("actual_end: expected %0h, got %0h", want.t_end, got.t_end);
          n_fail++;
        end
        if (got.delayed !== want.delayed) begin
          $error("was_delayed: expected %0d, got %0d", want.delayed, got.delayed);
          n_fail++;
        end
        if (got.busiest !== want.busiest) begin
          $error("busiest_room: expected %0d, got %0d", want.busiest, got.busiest);
          n_fail++;
        end
        if (got.done !== want.done) begin
          $error("batch_done: expected %0d, got %0d", want.done, got.done);
          n_fail++;
        end
      end
    end
  end

  // watchdog on cycles with no beat on either side and no room count write
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we_i)
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("timeout with %0d results outstanding", sched_q.size());
        $display("status: fail");
        $finish;
      end
    end
  end

  initial begin
    int rand_done;
    int blen;
    int span;
    int dspan;
    logic [IN_TIME_W-1:0] t;
    logic [IN_TIME_W-1:0] s;
    logic [IN_TIME_W-1:0] e;
    logic [IN_TIME_W-1:0] dur;

    clear_rooms();
    room_reg = RC_RESET;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    for (int r = 0; r < N_ROWS; r++) begin
      if (OPENING[r].is_cfg)
        write_rooms(OPENING[r].rooms);
      else
        send_meeting(OPENING[r].t_s, OPENING[r].t_e, OPENING[r].last_m,
                     OPENING[r].typed, OPENING[r].want);
    end

    // random batches: mostly sorted starts, some noise
    rand_done = 0;
    while (rand_done < RANDOM_MEETINGS) begin
      write_rooms(pick_rooms());
      blen = ($urandom_range(0, 7) == 0) ? $urandom_range(25, 60) : $urandom_range(1, 24);
      case ($urandom_range(0, 3))
        0:       t = IN_TIME_W'($urandom_range(0, 1000));
        1:       t = IN_TOP - IN_TIME_W'($urandom_range(0, 5000));
        default: t = rand_time();
      endcase
      case ($urandom_range(0, 3))
        0:       span = 0;
        1:       span = 3;
        2:       span = 40;
        default: span = 100000;
      endcase
      dspan = $urandom_range(0, 4);
      for (int k = 0; k < blen; k++) begin
        if ($urandom_range(0, 39) == 0) write_rooms(pick_rooms());
        if ($urandom_range(0, 59) == 0) wait_drained();
        if ($urandom_range(0, 9) == 0) begin
          s = rand_time();
          e = rand_time();
        end else begin
          case (dspan)
            0:       dur = IN_TIME_W'($urandom_range(0, 1));
            1:       dur = IN_TIME_W'($urandom_range(0, 10));
            2:       dur = IN_TIME_W'($urandom_range(0, 300));
            3:       dur = IN_TIME_W'($urandom_range(0, 1000000));
            default: dur = rand_time();
          endcase
          t = t + IN_TIME_W'($urandom_range(0, span));
          s = t;
          e = s + dur;
        end
        send_meeting(s, e, k == blen - 1, 1'b0, NO_WANT);
        rand_done++;
      end
    end

    // one room, longest durations: delayed ends climb to the 48-bit ceiling
    write_rooms(RC_W'(1));
    for (int k = 0; k < SAT_MEETINGS; k++)
      send_meeting(IN_TIME_W'(k), IN_TOP, k == SAT_MEETINGS - 1, 1'b0, NO_WANT);

    // flat-out run on one room with no stalls, then a second room opens
    write_rooms(RC_W'(1));
    fast = 1'b1;
    for (int k = 0; k < FAST_MEETINGS; k++)
      send_meeting('0, IN_TIME_W'(1), 1'b0, 1'b0, NO_WANT);
    write_rooms(RC_W'(2));
    send_meeting('0, IN_TIME_W'(1), 1'b1, 1'b0, NO_WANT);
    fast = 1'b0;

    wait_drained();
    repeat (DRAIN_WAIT) @(posedge clk_i);

    $display("covered %0d meetings over %0d batch closes, %0d delayed, %0d room count writes",
             n_meetings, n_closes, n_delayed, n_cfg);
    $display("included time saturation, a stall-free run and room count changes inside a batch");
    if (n_fail == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
